// File: design/jqd_pkg.sv
// Shared types and constants for the job queue with delete.
package jqd_pkg;

    localparam int JOB_W = 16;
    localparam int OP_W  = 2;
    localparam int OCC_W = 5;

    typedef logic [JOB_W-1:0] job_t;
    typedef logic [OP_W-1:0]  op_t;
    typedef logic [OCC_W-1:0] occ_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        job_t    job_out;
        status_t status;
        occ_t    occupancy;
    } result_t;

endpackage

// File: design/jqd_if.sv
// Request and response channel interfaces.
interface jqd_req_if;
    logic          valid;
    logic          ready;
    jqd_pkg::op_t  op;
    jqd_pkg::job_t job_id;

    modport source (output valid, output op, output job_id, input ready);
    modport sink   (input valid, input op, input job_id, output ready);
endinterface

interface jqd_rsp_if;
    logic           valid;
    logic           ready;
    jqd_pkg::job_t  job_out;
    logic [1:0]     status;
    jqd_pkg::occ_t  occupancy;

    modport source (output valid, output job_out, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input job_out, input status, input occupancy,
                    output ready);
endinterface

// File: design/jqd_mem.sv
// Job store: one write port, one read port with registered read data.
module jqd_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  jqd_pkg::job_t wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output jqd_pkg::job_t rdata
);

    jqd_pkg::job_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/jqd_seq.sv
// Sequencer: head/count bookkeeping, key compare and the delete scan/shift walk.
module jqd_seq #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  jqd_pkg::op_t      req_op,
    input  jqd_pkg::job_t     req_job_id,
    output logic              res_valid,
    input  logic              res_ready,
    output jqd_pkg::result_t  res
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);

    jqd_pkg::state_t state_reg, state_next;
    jqd_pkg::op_t    op_reg, op_next;
    jqd_pkg::job_t   key_reg, key_next;
    jqd_pkg::job_t   job_out_reg, job_out_next;
    jqd_pkg::status_t status_reg, status_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   rd_pos_reg, rd_pos_next;

    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    jqd_pkg::job_t   mem_wdata;
    jqd_pkg::job_t   mem_rdata;
    logic [CW-1:0]   wpos;

    logic            req_fire;
    logic            is_full;
    logic            is_empty;
    logic            hit;
    logic            last;
    logic            more;

    // ring position to slot; pos never exceeds the depth
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [SW-1:0] s;
        begin
            s = SW'(head) + SW'(pos);
            if (s >= DEPTH_S)
            begin
                s = s - DEPTH_S;
            end
            return s[AW-1:0];
        end
    endfunction

    assign req_fire = req_valid && req_ready;
    assign is_full  = (SW'(count_reg) >= DEPTH_S);
    assign is_empty = (count_reg == '0);
    assign hit      = (mem_rdata == key_reg);
    assign last     = ((SW'(pos_reg) + SW'(1)) == SW'(count_reg));
    assign more     = ((SW'(pos_reg) + SW'(1)) < SW'(count_reg));

    jqd_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jqd_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = jqd_pkg::S_DECODE;
                end
            end
            jqd_pkg::S_DECODE:
            begin
                case (op_reg)
                    jqd_pkg::OP_POP:
                        state_next = is_empty ? jqd_pkg::S_DONE : jqd_pkg::S_POP;
                    jqd_pkg::OP_DELETE:
                        state_next = is_empty ? jqd_pkg::S_DONE : jqd_pkg::S_SCAN;
                    default:
                        state_next = jqd_pkg::S_DONE;
                endcase
            end
            jqd_pkg::S_POP:
                state_next = jqd_pkg::S_DONE;
            jqd_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    state_next = jqd_pkg::S_SHIFT;
                end
                else if (last)
                begin
                    state_next = jqd_pkg::S_DONE;
                end
            end
            jqd_pkg::S_SHIFT:
            begin
                if (!more)
                begin
                    state_next = jqd_pkg::S_DONE;
                end
            end
            jqd_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = jqd_pkg::S_IDLE;
                end
            end
            default:
                state_next = jqd_pkg::S_IDLE;
        endcase
    end

    // outputs: handshakes and memory ports
    always_comb
    begin
        req_ready = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = key_reg;
        wpos      = pos_reg;
        case (state_reg)
            jqd_pkg::S_IDLE:
                req_ready = 1'b1;
            jqd_pkg::S_DECODE:
            begin
                // read the head for pop or the first compare of delete
                mem_re = 1'b1;
                wpos   = count_reg;
                mem_we = (op_reg == jqd_pkg::OP_ADD) && !is_full;
            end
            jqd_pkg::S_SCAN:
                mem_re = 1'b1;
            jqd_pkg::S_SHIFT:
            begin
                // move the entry behind one slot toward the head
                mem_we    = more;
                mem_re    = more;
                mem_wdata = mem_rdata;
            end
            jqd_pkg::S_DONE:
                res_valid = 1'b1;
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        mem_waddr = slot_of(head_reg, wpos);
        mem_raddr = slot_of(head_reg, rd_pos_reg);
    end

    // datapath
    always_comb
    begin
        op_next      = op_reg;
        key_next     = key_reg;
        job_out_next = job_out_reg;
        status_next  = status_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        rd_pos_next  = rd_pos_reg;
        case (state_reg)
            jqd_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next      = req_op;
                    key_next     = req_job_id;
                    job_out_next = '0;
                    status_next  = jqd_pkg::ST_OK;
                    pos_next     = '0;
                    rd_pos_next  = '0;
                end
            end
            jqd_pkg::S_DECODE:
            begin
                rd_pos_next = rd_pos_reg + CW'(1);
                case (op_reg)
                    jqd_pkg::OP_ADD:
                    begin
                        if (is_full)
                        begin
                            status_next = jqd_pkg::ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    jqd_pkg::OP_POP:
                    begin
                        if (is_empty)
                        begin
                            status_next = jqd_pkg::ST_EMPTY;
                        end
                    end
                    jqd_pkg::OP_DELETE:
                    begin
                        if (is_empty)
                        begin
                            status_next = jqd_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        status_next = jqd_pkg::ST_OK;
                    end
                endcase
            end
            jqd_pkg::S_POP:
            begin
                job_out_next = mem_rdata;
                head_next    = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
                count_next   = count_reg - CW'(1);
            end
            jqd_pkg::S_SCAN:
            begin
                rd_pos_next = rd_pos_reg + CW'(1);
                if (hit)
                begin
                    job_out_next = mem_rdata;
                end
                else if (last)
                begin
                    status_next = jqd_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            jqd_pkg::S_SHIFT:
            begin
                if (more)
                begin
                    pos_next    = pos_reg + CW'(1);
                    rd_pos_next = rd_pos_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jqd_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        job_out_reg <= job_out_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        rd_pos_reg  <= rd_pos_next;
    end

    assign res.job_out   = job_out_reg;
    assign res.status    = status_reg;
    assign res.occupancy = jqd_pkg::OCC_W'(count_reg);

endmodule

// File: design/job_queue_with_delete_unit.sv
// Top level of the job queue with delete: sequencer plus response register.
//
//   channel  dir  fields                      accepted when
//   req      in   op, job_id                  req.valid && req.ready
//   rsp      out  job_out, status, occupancy  rsp.valid && rsp.ready
//
// Add steps through DECODE and DONE, pop through DECODE, POP and DONE, delete through
// DECODE, SCAN, SHIFT and DONE (a miss skips SHIFT; empty goes DECODE to DONE). The walk
// reads one entry per cycle through the single store read port, comparing, then moving.
// Reset clears head and count; the store itself holds no reset value.
// A result waits in the response register; the next item is accepted meanwhile,
// and the sequencer holds its finished result while that register is still full.
module job_queue_with_delete_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    jqd_req_if.sink           req,
    jqd_rsp_if.source         rsp
);

    jqd_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;
    logic             out_valid_reg, out_valid_next;
    jqd_pkg::result_t out_reg, out_next;

    jqd_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_op     (req.op),
        .req_job_id (req.job_id),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.job_out   = out_reg.job_out;
    assign rsp.status    = out_reg.status;
    assign rsp.occupancy = out_reg.occupancy;

`ifndef SYNTHESIS
    a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == jqd_pkg::ST_FULL)
            |-> rsp.occupancy == jqd_pkg::OCC_W'(QUEUE_DEPTH))
        else $error("full reported below depth");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == jqd_pkg::ST_EMPTY) |-> rsp.occupancy == '0)
        else $error("empty reported with jobs held");

    a_fail_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != jqd_pkg::ST_OK) |-> rsp.job_out == '0)
        else $error("failed request returned a job");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item accepted while previous one in progress");
`endif

endmodule

// File: dv/job_queue_with_delete_unit_tb.sv
// Self-checking testbench for the job queue with delete, checked against a queue predictor.
`timescale 1ns / 100ps

module job_queue_with_delete_unit_tb;

    localparam int           QDEPTH      = 16;
    localparam jqd_pkg::op_t OP_UNUSED   = 2'd3;
    localparam int           RANDOM_JOBS = 1400;
    localparam int           QUIET_TAIL  = 120;
    localparam int           MAX_IDLE    = 14;

    typedef struct packed {
        jqd_pkg::op_t  op;
        jqd_pkg::job_t job_id;
    } request_t;

    logic clk;
    logic rst_n;

    jqd_req_if req_bus ();
    jqd_rsp_if rsp_bus ();

    job_queue_with_delete_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    request_t          pending_requests[$];
    jqd_pkg::result_t  expected_results[$];

    // Predictor state
    jqd_pkg::job_t model_jobs[QDEPTH];
    int   model_head;
    int   model_count;

    int mismatch_count;
    int total_items;
    int results_seen;
    int send_gap;
    int send_idle_pct;
    int stall_left;
    int stall_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic int slot_at(int pos);
        return (model_head + pos) % QDEPTH;
    endfunction

    function automatic jqd_pkg::result_t apply_request(jqd_pkg::op_t op, jqd_pkg::job_t key);
        jqd_pkg::result_t r;
        int      pos;
        bit      found;
        r.job_out = '0;
        r.status  = jqd_pkg::ST_OK;
        case (op)
            jqd_pkg::OP_ADD:
            begin
                if (model_count >= QDEPTH)
                    r.status = jqd_pkg::ST_FULL;
                else
                begin
                    model_jobs[slot_at(model_count)] = key;
                    model_count++;
                end
            end
            jqd_pkg::OP_POP:
            begin
                if (model_count == 0)
                    r.status = jqd_pkg::ST_EMPTY;
                else
                begin
                    r.job_out  = model_jobs[model_head];
                    model_head = (model_head + 1) % QDEPTH;
                    model_count--;
                end
            end
            jqd_pkg::OP_DELETE:
            begin
                found = 1'b0;
                pos   = 0;
                while (pos < model_count && !found)
                begin
                    if (model_jobs[slot_at(pos)] == key)
                        found = 1'b1;
                    else
                        pos++;
                end
                if (!found)
                    r.status = jqd_pkg::ST_NOT_FOUND;
                else
                begin
                    r.job_out = model_jobs[slot_at(pos)];
                    // close the gap, keeping order
                    for (int p = pos; p + 1 < model_count; p++)
                        model_jobs[slot_at(p)] = model_jobs[slot_at(p + 1)];
                    model_count--;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = jqd_pkg::occ_t'(model_count);
        return r;
    endfunction

    task automatic queue_request(jqd_pkg::op_t op, jqd_pkg::job_t id);
        request_t item;
        item.op     = op;
        item.job_id = id;
        pending_requests.push_back(item);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t item;
        if (!rst_n)
        begin
            req_bus.valid  <= 1'b0;
            req_bus.op     <= jqd_pkg::OP_ADD;
            req_bus.job_id <= '0;
            send_gap        = 0;
            send_idle_pct   = 20;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                expected_results.push_back(apply_request(req_bus.op, req_bus.job_id));
            if ($urandom_range(1, 50) == 1)
                send_idle_pct = $urandom_range(0, 3) * 15;
            if (!req_bus.valid || req_bus.ready)
            begin
                if (pending_requests.size() < QUIET_TAIL)
                    send_gap = 0;
                else if (send_gap == 0 && $urandom_range(1, 100) <= send_idle_pct)
                    send_gap = $urandom_range(1, MAX_IDLE);
                if (send_gap > 0 || pending_requests.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    req_bus.valid <= 1'b0;
                end
                else
                begin
                    item = pending_requests.pop_front();
                    req_bus.valid  <= 1'b1;
                    req_bus.op     <= item.op;
                    req_bus.job_id <= item.job_id;
                end
            end
        end
    end

    // Response monitor
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        jqd_pkg::result_t want;
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left     = 0;
            stall_idle_pct = 20;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result job_out=%h status=%0d occ=%0d",
                                              rsp_bus.job_out, rsp_bus.status, rsp_bus.occupancy));
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_bus.job_out !== want.job_out)
                        report_mismatch($sformatf("job_out %h, expected %h",
                                                  rsp_bus.job_out, want.job_out));
                    if (rsp_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_bus.status, want.status));
                    if (rsp_bus.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, expected %0d",
                                                  rsp_bus.occupancy, want.occupancy));
                end
            end
            if ($urandom_range(1, 50) == 1)
                stall_idle_pct = $urandom_range(0, 3) * 15;
            if (results_seen >= total_items - QUIET_TAIL)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(1, 100) <= stall_idle_pct)
                stall_left = $urandom_range(1, MAX_IDLE);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int            add_pct;
        int            pick;
        jqd_pkg::op_t  op;
        jqd_pkg::job_t id;

        rst_n          = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.op     = jqd_pkg::OP_ADD;
        req_bus.job_id = '0;
        rsp_bus.ready  = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        model_head     = 0;
        model_count    = 0;

        // Directed: empty cases, fill to full, deletes at head, middle, tail and miss
        queue_request(jqd_pkg::OP_POP, 16'h0000);
        queue_request(jqd_pkg::OP_DELETE, 16'h1234);
        queue_request(OP_UNUSED, 16'hFFFF);
        queue_request(jqd_pkg::OP_ADD, 16'h0000);
        queue_request(jqd_pkg::OP_ADD, 16'hFFFF);
        queue_request(jqd_pkg::OP_ADD, 16'hAAAA);
        queue_request(jqd_pkg::OP_ADD, 16'h5555);
        queue_request(jqd_pkg::OP_ADD, 16'h0000);
        for (int i = 6; i <= 16; i++)
            queue_request(jqd_pkg::OP_ADD, jqd_pkg::job_t'(16'h0101 * i));
        queue_request(jqd_pkg::OP_ADD, 16'h4321);
        queue_request(jqd_pkg::OP_DELETE, 16'h0000);
        queue_request(jqd_pkg::OP_DELETE, 16'h5555);
        queue_request(jqd_pkg::OP_DELETE, 16'h1010);
        queue_request(jqd_pkg::OP_DELETE, 16'h7777);
        queue_request(jqd_pkg::OP_POP, 16'h0000);

        // Random: alternate fill-heavy and drain-heavy stretches
        for (int n = 0; n < RANDOM_JOBS; n++)
        begin
            add_pct = ((n / 40) % 2 == 0) ? 80 : 15;
            pick    = $urandom_range(1, 100);
            if (pick <= 3)
                op = OP_UNUSED;
            else if (pick <= 3 + add_pct)
                op = jqd_pkg::OP_ADD;
            else if ($urandom_range(0, 1) == 0)
                op = jqd_pkg::OP_POP;
            else
                op = jqd_pkg::OP_DELETE;
            // small keys give duplicates and frequent delete hits
            if ($urandom_range(1, 100) <= 70)
                id = jqd_pkg::job_t'($urandom_range(0, 15));
            else
                id = jqd_pkg::job_t'($urandom_range(0, 65535));
            queue_request(op, id);
        end
        total_items = pending_requests.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !req_bus.valid);
        wait (expected_results.size() == 0);
        repeat (64) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
